// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer: screen geometry, op and character codes,
// controller/datapath command and status types. No dependencies.
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 16;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_BACK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_BLANK_HERE = 8'h08;
    localparam logic [7:0] CH_ERROR      = 8'h45;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

    typedef logic [1:0] t_sweep;
    localparam t_sweep SW_COPY  = 2'd0;
    localparam t_sweep SW_ZERO  = 2'd1;
    localparam t_sweep SW_BLANK = 2'd2;

    typedef struct packed {
        logic   capture;
        logic   exec;
        logic   sweep;
        t_sweep sweep_kind;
        logic   finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       scroll;
        logic       copy_last;
        logic       fill_last;
    } t_stat;

endpackage

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: APB configuration registers, controller and datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// An 80x25 text screen (char + attribute per cell) with a cursor. Commands are taken when
// start is high and busy is low; each produces one result on o_done for a single cycle,
// which the receiver must take as it comes. A put, blank-in-place, backspace or error put
// goes through capture and one store write, and busy drops as the result appears; a read
// also waits for the registered store read. A put that moves past the last cell scrolls
// the screen through the store's one write port: 1920 cells are copied up a row and the
// last 80 are zero-filled; a clear fills all 2000 cells with blanks. After reset, busy
// stays high while the store is zeroed, one cell a cycle.
module text_console_writer import tcw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_char_code,
    input  logic [7:0]         i_attr,
    input  logic               i_use_position,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_row,
    output logic               o_done,
    output logic [COL_W-1:0]   o_cursor_col,
    output logic [ROW_W-1:0]   o_cursor_row,
    output logic               o_pos_error,
    output logic [7:0]         o_read_char,
    output logic [7:0]         o_read_attr,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] r_default_attr;
    logic [7:0] r_error_attr;
    logic       cfg_wr;
    t_cmd       cmd;
    t_stat      stat;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {24'd0, r_error_attr} : {24'd0, r_default_attr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= DEFAULT_ATTR_RST;
            r_error_attr   <= ERROR_ATTR_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_error_attr <= pwdata[7:0];
            end else begin
                r_default_attr <= pwdata[7:0];
            end
        end
    end

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tcw_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_default_attr (r_default_attr),
        .i_error_attr   (r_error_attr),
        .i_op           (i_op),
        .i_char_code    (i_char_code),
        .i_attr         (i_attr),
        .i_use_position (i_use_position),
        .i_col          (i_col),
        .i_row          (i_row),
        .o_done         (o_done),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_pos_error    (o_pos_error),
        .o_read_char    (o_read_char),
        .o_read_attr    (o_read_attr)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transfer");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_cursor_col < COL_W'(COLS)) && (o_cursor_row < ROW_W'(ROWS)))
        else $error("cursor outside screen");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_pos_error |-> (o_read_char == 8'd0) && (o_read_attr == 8'd0))
        else $error("read data on position error");

    a_sweep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sweep |-> !cmd.capture && !cmd.exec)
        else $error("sweep overlaps item write");

endmodule

// ===== rtl/tcw_datapath.sv =====
// Datapath: screen store, cursor, item registers, sweep counter and result registers.
// Depends on tcw_pkg; driven by tcw_ctrl.
module tcw_datapath import tcw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [7:0]         i_default_attr,
    input  logic [7:0]         i_error_attr,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_char_code,
    input  logic [7:0]         i_attr,
    input  logic               i_use_position,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_row,
    output logic               o_done,
    output logic [COL_W-1:0]   o_cursor_col,
    output logic [ROW_W-1:0]   o_cursor_row,
    output logic               o_pos_error,
    output logic [7:0]         o_read_char,
    output logic [7:0]         o_read_attr
);

    logic [CELL_W-1:0] r_mem [0:CELLS-1];
    logic [CELL_W-1:0] r_mem_q;
    logic [ADDR_W-1:0] rd_addr;

    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [1:0]        r_op;
    logic              r_err;
    logic              r_scroll;
    logic              r_we;
    logic [ADDR_W-1:0] r_addr;
    logic [CELL_W-1:0] r_wdata;

    logic [ADDR_W-1:0] r_cnt;
    logic              r_sw_pend;
    logic              r_sw_copy;
    logic [ADDR_W-1:0] r_sw_addr;
    logic [CELL_W-1:0] r_sw_data;
    logic              r_done;

    // capture-time decode
    logic              in_range;
    logic              pos_bad;
    logic [COL_W-1:0]  base_col;
    logic [ROW_W-1:0]  base_row;
    logic [COL_W-1:0]  prev_col;
    logic [ROW_W-1:0]  prev_row;
    logic [7:0]        eff_attr;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  a_col;
    logic [ROW_W-1:0]  a_row;
    logic              n_we;
    logic              n_err;
    logic              n_scroll;
    logic              use_last;
    logic [CELL_W-1:0] n_wdata;
    logic [ADDR_W-1:0] n_addr;

    always_comb begin
        in_range = (i_col < 8'(COLS)) && (i_row < 8'(ROWS));
        pos_bad  = i_use_position && !in_range;
        base_col = i_use_position ? i_col[COL_W-1:0] : r_cur_col;
        base_row = i_use_position ? i_row[ROW_W-1:0] : r_cur_row;
        eff_attr = (i_attr == 8'd0) ? i_default_attr : i_attr;
        if (r_cur_col != '0) begin
            prev_col = r_cur_col - 1'b1;
            prev_row = r_cur_row;
        end else if (r_cur_row != '0) begin
            prev_col = COL_W'(COLS - 1);
            prev_row = r_cur_row - 1'b1;
        end else begin
            prev_col = '0;
            prev_row = '0;
        end

        n_col    = r_cur_col;
        n_row    = r_cur_row;
        a_col    = base_col;
        a_row    = base_row;
        n_we     = 1'b0;
        n_err    = 1'b0;
        n_scroll = 1'b0;
        use_last = 1'b0;
        n_wdata  = {eff_attr, i_char_code};
        case (i_op)
            OP_PUT: begin
                if (pos_bad) begin
                    n_err    = 1'b1;
                    n_we     = 1'b1;
                    use_last = 1'b1;
                    n_wdata  = {i_error_attr, CH_ERROR};
                end else begin
                    if (i_char_code == CH_NEWLINE) begin
                        n_col = '0;
                        n_row = base_row + 1'b1;
                    end else if (i_char_code == CH_BLANK_HERE) begin
                        n_we    = 1'b1;
                        n_wdata = {eff_attr, CH_SPACE};
                        n_col   = base_col;
                        n_row   = base_row;
                    end else begin
                        n_we = 1'b1;
                        if (base_col == COL_W'(COLS - 1)) begin
                            n_col = '0;
                            n_row = base_row + 1'b1;
                        end else begin
                            n_col = base_col + 1'b1;
                            n_row = base_row;
                        end
                    end
                    if (n_row == ROW_W'(ROWS)) begin
                        n_scroll = 1'b1;
                        n_row    = ROW_W'(ROWS - 1);
                    end
                end
            end
            OP_BACK: begin
                a_col   = prev_col;
                a_row   = prev_row;
                n_we    = 1'b1;
                n_wdata = {i_default_attr, CH_SPACE};
                n_col   = prev_col;
                n_row   = prev_row;
            end
            OP_CLEAR: begin
                n_col = '0;
                n_row = '0;
            end
            default: begin
                n_err = pos_bad;
            end
        endcase
        n_addr = use_last ? ADDR_W'(CELLS - 1)
                          : ADDR_W'(a_row * ADDR_W'(COLS)) + ADDR_W'(a_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_cnt     <= '0;
            r_sw_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.capture) begin
                r_cur_col <= n_col;
                r_cur_row <= n_row;
                r_cnt     <= '0;
            end else if (i_cmd.sweep) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_sw_pend <= i_cmd.sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_err    <= n_err;
            r_scroll <= n_scroll;
            r_we     <= n_we;
            r_addr   <= n_addr;
            r_wdata  <= n_wdata;
        end
        if (i_cmd.sweep) begin
            r_sw_addr <= r_cnt;
            r_sw_copy <= (i_cmd.sweep_kind == SW_COPY);
            r_sw_data <= (i_cmd.sweep_kind == SW_BLANK) ? {i_default_attr, CH_SPACE} : '0;
        end
        if (i_cmd.finish) begin
            o_cursor_col <= r_cur_col;
            o_cursor_row <= r_cur_row;
            o_pos_error  <= r_err;
            if (r_op == OP_READ && !r_err) begin
                o_read_char <= r_mem_q[7:0];
                o_read_attr <= r_mem_q[15:8];
            end else begin
                o_read_char <= '0;
                o_read_attr <= '0;
            end
        end
    end

    // screen store: one write port, one registered read port
    assign rd_addr = (i_cmd.sweep && i_cmd.sweep_kind == SW_COPY)
                   ? r_cnt + ADDR_W'(COLS) : r_addr;

    always_ff @(posedge i_clk) begin
        if (r_sw_pend) begin
            r_mem[r_sw_addr] <= r_sw_copy ? r_mem_q : r_sw_data;
        end else if (i_cmd.exec && r_we) begin
            r_mem[r_addr] <= r_wdata;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    assign o_done           = r_done;
    assign o_stat.op        = r_op;
    assign o_stat.scroll    = r_scroll;
    assign o_stat.copy_last = (r_cnt == ADDR_W'(CELLS - COLS - 1));
    assign o_stat.fill_last = (r_cnt == ADDR_W'(CELLS - 1));

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller: sequences capture, cell write/read, scroll and fill sweeps, result strobe.
// Depends on tcw_pkg; drives tcw_datapath.
module tcw_ctrl import tcw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_COPY   = 3'd4;
    localparam logic [2:0] S_ZERO   = 3'd5;
    localparam logic [2:0] S_FILL   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.sweep_kind = SW_ZERO;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_stat.op)
                    OP_CLEAR: n_state = S_FILL;
                    OP_READ:  n_state = S_RDWAIT;
                    default: begin
                        if (i_stat.op == OP_PUT && i_stat.scroll) begin
                            n_state = S_COPY;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_RDWAIT: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_COPY: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.sweep_kind = SW_COPY;
                if (i_stat.copy_last) begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.sweep_kind = SW_ZERO;
                if (i_stat.fill_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.sweep_kind = SW_BLANK;
                if (i_stat.fill_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for text_console_writer: directed and random command transfers,
// APB register writes between phases, and a cycle-free screen predictor checked per result.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 100ps

module testbench;
    import tcw_pkg::*;

    localparam logic [2:0] REG_DEFAULT_ATTR = 3'd0;
    localparam logic [2:0] REG_ERROR_ATTR   = 3'd4;
    localparam int         DRAIN_LIMIT      = 10000;
    localparam int         PHASE_ITEMS      = 420;

    typedef struct {
        logic [COL_W-1:0] cur_col;
        logic [ROW_W-1:0] cur_row;
        logic             pos_err;
        logic [7:0]       rd_char;
        logic [7:0]       rd_attr;
    } t_console_status;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_op;
    logic [7:0]       i_char_code;
    logic [7:0]       i_attr;
    logic             i_use_position;
    logic [7:0]       i_col;
    logic [7:0]       i_row;
    logic             o_done;
    logic [COL_W-1:0] o_cursor_col;
    logic [ROW_W-1:0] o_cursor_row;
    logic             o_pos_error;
    logic [7:0]       o_read_char;
    logic [7:0]       o_read_attr;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    text_console_writer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_char_code    (i_char_code),
        .i_attr         (i_attr),
        .i_use_position (i_use_position),
        .i_col          (i_col),
        .i_row          (i_row),
        .o_done         (o_done),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_pos_error    (o_pos_error),
        .o_read_char    (o_read_char),
        .o_read_attr    (o_read_attr),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // predicted screen contents: {attr, char} per cell
    logic [15:0]     screen_mem [CELLS];
    int              cursor_at;
    logic [7:0]      cfg_default_attr;
    logic [7:0]      cfg_error_attr;
    t_console_status pending_status [$];
    int              mismatches;
    bit              gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic scroll_screen();
        for (int i = 0; i < CELLS - COLS; i++) screen_mem[i] = screen_mem[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen_mem[i] = 16'h0000;
    endtask

    task automatic advance_console(input logic [1:0] op, input logic [7:0] ch,
                                   input logic [7:0] at, input logic use_pos,
                                   input logic [7:0] col, input logic [7:0] row,
                                   output t_console_status st);
        int  pos;
        bit  in_range;
        logic [7:0] cell_attr;
        in_range   = (int'(col) < COLS) && (int'(row) < ROWS);
        st.pos_err = 1'b0;
        st.rd_char = 8'd0;
        st.rd_attr = 8'd0;
        case (op)
            OP_PUT: begin
                cell_attr = (at == 8'd0) ? cfg_default_attr : at;
                if (use_pos && !in_range) begin
                    screen_mem[CELLS-1] = {cfg_error_attr, CH_ERROR};
                    st.pos_err = 1'b1;
                end else begin
                    pos = use_pos ? int'(row) * COLS + int'(col) : cursor_at;
                    if (ch == CH_NEWLINE) begin
                        pos = (pos / COLS + 1) * COLS;
                    end else if (ch == CH_BLANK_HERE) begin
                        screen_mem[pos] = {cell_attr, CH_SPACE};
                    end else begin
                        screen_mem[pos] = {cell_attr, ch};
                        pos++;
                    end
                    if (pos >= CELLS) begin
                        scroll_screen();
                        pos -= COLS;
                    end
                    cursor_at = pos;
                end
            end
            OP_BACK: begin
                pos = (cursor_at > 0) ? cursor_at - 1 : 0;
                screen_mem[pos] = {cfg_default_attr, CH_SPACE};
                cursor_at = pos;
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen_mem[i] = {cfg_default_attr, CH_SPACE};
                cursor_at = 0;
            end
            default: begin
                if (use_pos && !in_range) begin
                    st.pos_err = 1'b1;
                end else begin
                    pos = use_pos ? int'(row) * COLS + int'(col) : cursor_at;
                    st.rd_char = screen_mem[pos][7:0];
                    st.rd_attr = screen_mem[pos][15:8];
                end
            end
        endcase
        st.cur_col = COL_W'(cursor_at % COLS);
        st.cur_row = ROW_W'(cursor_at / COLS);
    endtask

    task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] at,
                            input logic use_pos, input logic [7:0] col, input logic [7:0] row);
        t_console_status st;
        int gap;
        if (gaps_on && $urandom_range(0, 99) < 16) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          = 1'b1;
        i_op           = op;
        i_char_code    = ch;
        i_attr         = at;
        i_use_position = use_pos;
        i_col          = col;
        i_row          = row;
        do @(posedge i_clk); while (busy !== 1'b0);
        advance_console(op, ch, at, use_pos, col, row, st);
        pending_status.push_back(st);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(negedge i_clk);
        start = 1'b0;
        while ((pending_status.size() != 0 || busy !== 1'b0) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            mismatches++;
            $display("drain timed out with %0d results outstanding", pending_status.size());
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [7:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {24'd0, data};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == REG_DEFAULT_ATTR) cfg_default_attr = data;
        else                          cfg_error_attr   = data;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_attrs(input logic [7:0] def_attr, input logic [7:0] err_attr);
        drain();
        apb_write(REG_DEFAULT_ATTR, def_attr);
        apb_write(REG_ERROR_ATTR, err_attr);
    endtask

    task automatic test_put_and_read();
        send_cmd(OP_PUT, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
        send_cmd(OP_PUT, 8'hFF, 8'hFF, 1'b0, 8'd0, 8'd0);
        send_cmd(OP_PUT, CH_BLANK_HERE, 8'h5A, 1'b0, 8'd0, 8'd0);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b1, 8'd0, 8'd0);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
        send_cmd(OP_PUT, CH_NEWLINE, 8'h00, 1'b0, 8'd0, 8'd0);
        send_cmd(OP_PUT, 8'h41, 8'h71, 1'b1, 8'd79, 8'd0);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b1, 8'd79, 8'd0);
    endtask

    task automatic test_position_error();
        send_cmd(OP_PUT, 8'h42, 8'h33, 1'b1, 8'd80, 8'd0);
        send_cmd(OP_PUT, 8'h43, 8'h00, 1'b1, 8'd0, 8'd25);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b1, 8'd255, 8'd255);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b1, 8'd79, 8'd24);
    endtask

    task automatic test_backspace_clear();
        send_cmd(OP_CLEAR, 8'hFF, 8'hFF, 1'b1, 8'd255, 8'd255);
        send_cmd(OP_BACK, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
        send_cmd(OP_PUT, 8'h78, 8'h00, 1'b0, 8'd0, 8'd0);
        send_cmd(OP_BACK, 8'hFF, 8'hFF, 1'b1, 8'd200, 8'd200);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
    endtask

    task automatic test_scroll();
        send_cmd(OP_PUT, 8'h5A, 8'h1E, 1'b1, 8'd79, 8'd24);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b1, 8'd79, 8'd23);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b1, 8'd0, 8'd24);
        send_cmd(OP_PUT, CH_NEWLINE, 8'h00, 1'b1, 8'd5, 8'd24);
        send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
    endtask

    task automatic send_random_cmd();
        logic [1:0] op;
        logic [7:0] ch, at, col, row;
        logic       use_pos;
        int         pick;
        pick    = $urandom_range(0, 99);
        op      = (pick < 68) ? OP_PUT : (pick < 78) ? OP_BACK : (pick < 80) ? OP_CLEAR : OP_READ;
        pick    = $urandom_range(0, 99);
        ch      = (pick < 10) ? CH_NEWLINE : (pick < 15) ? CH_BLANK_HERE : 8'($urandom);
        at      = ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom);
        use_pos = ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 99) < 85) begin
            col = 8'($urandom_range(0, COLS - 1));
            row = ($urandom_range(0, 99) < 30) ? 8'(ROWS - 1) : 8'($urandom_range(0, ROWS - 1));
        end else begin
            col = 8'($urandom);
            row = 8'($urandom);
        end
        if (op == OP_BACK || op == OP_CLEAR) use_pos = 1'($urandom);
        send_cmd(op, ch, at, use_pos, col, row);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_attrs(8'h00, 8'hFF);
                1: set_attrs(8'hFF, 8'h00);
                2: set_attrs(8'($urandom), 8'($urandom));
                default: set_attrs(DEFAULT_ATTR_RST, ERROR_ATTR_RST);
            endcase
            gaps_on = (phase != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == PHASE_ITEMS / 2) drain();
                send_random_cmd();
            end
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else if (o_cursor_col !== pending_status[0].cur_col ||
                         o_cursor_row !== pending_status[0].cur_row ||
                         o_pos_error  !== pending_status[0].pos_err ||
                         o_read_char  !== pending_status[0].rd_char ||
                         o_read_attr  !== pending_status[0].rd_attr) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: exp col=%0d row=%0d err=%0b ch=%h at=%h",
                             $realtime, pending_status[0].cur_col, pending_status[0].cur_row,
                             pending_status[0].pos_err, pending_status[0].rd_char,
                             pending_status[0].rd_attr);
                    $display("    got col=%0d row=%0d err=%0b ch=%h at=%h",
                             o_cursor_col, o_cursor_row, o_pos_error,
                             o_read_char, o_read_attr);
                end
                void'(pending_status.pop_front());
            end else begin
                void'(pending_status.pop_front());
            end
        end
    end

    initial begin
        start            = 1'b0;
        i_op             = OP_PUT;
        i_char_code      = 8'd0;
        i_attr           = 8'd0;
        i_use_position   = 1'b0;
        i_col            = 8'd0;
        i_row            = 8'd0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = REG_DEFAULT_ATTR;
        pwdata           = 32'd0;
        i_rst_n          = 1'b0;
        mismatches       = 0;
        gaps_on          = 1'b1;
        cursor_at        = 0;
        cfg_default_attr = DEFAULT_ATTR_RST;
        cfg_error_attr   = ERROR_ATTR_RST;
        for (int i = 0; i < CELLS; i++) screen_mem[i] = 16'h0000;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_put_and_read();
        test_position_error();
        test_backspace_clear();
        test_scroll();
        test_random();

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
